>>> hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the point matcher datapath.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// checked after reset only
`define UV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked on every edge, reset included
`define UV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define UV_ASSERT(lbl, prop, msg)
`define UV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> hdl/uvswpm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvswpm_pkg
// Constants, codes and controller/datapath types of the U/V point matcher.
// ---------------------------------------------------------------------------
package uvswpm_pkg;

    localparam int NUM_WIRES  = 128;
    localparam int MAX_HITS   = 16;
    localparam int RESULT_CAP = 16;

    localparam int WIRE_W     = $clog2(NUM_WIRES);
    // window bounds before clamping reach -132 .. 229
    localparam int WIN_W      = ((WIRE_W > 9) ? WIRE_W : 9) + 2;
    localparam int CNT_W      = $clog2(MAX_HITS + 2);
    localparam int EMIT_MAX   = (MAX_HITS < RESULT_CAP) ? MAX_HITS : RESULT_CAP;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int ROOT_W     = 16;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;

    localparam int MUL_A_W    = 18;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    localparam int WIRE_OFFSET = 60;
    localparam int STRIP_SUM   = 239;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_MARK  = 2'd1,
        MODE_PAIR  = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_COS = 1'b0,
        CFG_ROT_SIN = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_SQ_L,
        MUL_SQ_R,
        MUL_SQ_Y,
        MUL_Y_SIN,
        MUL_Y_COS,
        MUL_X_COS,
        MUL_X_SIN
    } mul_sel_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_L,
        ST_RT_L,
        ST_WT_L,
        ST_SQ_R,
        ST_RT_R,
        ST_WT_R,
        ST_CHK,
        ST_SQ_Y,
        ST_RT_Y,
        ST_WT_Y,
        ST_M_YS,
        ST_M_YC,
        ST_COUNT,
        ST_E_INIT,
        ST_E_SCAN,
        ST_E_MS,
        ST_E_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic     accept_en;
        mul_sel_t mul_sel;
        logic     isq_start;
        logic     isq_short;
        logic     cap_left;
        logic     cap_right;
        logic     cap_y;
        logic     idx_load;
        logic     idx_inc;
        logic     cnt_clr;
        logic     cnt_acc;
        logic     n_clr;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic       req_valid;
        logic [1:0] req_mode;
        logic       isq_busy;
        logic       win_empty;
        logic       hit;
        logic       at_right;
        logic       cnt_zero;
        logic       is_last;
        logic       out_busy;
    } dp_stat_t;

endpackage

>>> hdl/uvswpm_in_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvswpm_in_if
// Request channel: wire map commands and U/V cluster pairs.
// ---------------------------------------------------------------------------
interface uvswpm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [6:0] wire_req;
    logic [7:0] u_begin;
    logic [7:0] u_end;
    logic [7:0] u_peak;
    logic [7:0] u_width;
    logic [7:0] v_begin;
    logic [7:0] v_end;
    logic [7:0] v_peak;
    logic [7:0] v_width;
    logic [4:0] layer;

    modport source (
        output valid, mode, wire_req, u_begin, u_end, u_peak, u_width,
               v_begin, v_end, v_peak, v_width, layer,
        input  ready
    );

    modport sink (
        input  valid, mode, wire_req, u_begin, u_end, u_peak, u_width,
               v_begin, v_end, v_peak, v_width, layer,
        output ready
    );
endinterface

>>> hdl/uvswpm_out_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvswpm_out_if
// Point channel: one space point per hit wire of a U/V pair, up to a limit.
// ---------------------------------------------------------------------------
interface uvswpm_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] x_pos;
    logic signed [16:0] y_pos;
    logic [4:0]         point_layer;
    logic [7:0]         resolution;
    logic               overflow;
    logic               last;

    modport source (
        output valid, x_pos, y_pos, point_layer, resolution, overflow, last,
        input  ready
    );

    modport sink (
        input  valid, x_pos, y_pos, point_layer, resolution, overflow, last,
        output ready
    );
endinterface

>>> hdl/uv_strip_wire_point_matcher_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uv_strip_wire_point_matcher_unit
// Space point former for one chamber layer from U/V clusters and hit wires.
// ---------------------------------------------------------------------------
// Usage
//   req    valid/ready request channel. Mode 0 clears the hit wire map, mode 1
//          marks one wire, mode 2 matches a U/V cluster pair, mode 3 is dropped.
//   point  valid/ready channel, one space point per hit wire in a pair's window,
//          up to the limit; last marks the final point of a pair, overflow is set
//          on every point of a pair whose window held more hits than the limit.
//   cfg_*  write port for the rotation cosine (index 0) and sine (index 1),
//          Q1.14, written while the block is idle.
// Sequence
//   Modes 0, 1 and 3 leave the block idle and ready for the next request. A pair
//   is set up after it is taken (two 8-step and one 16-step square roots on one
//   shared root unit, each waited out until the unit is no longer busy, plus
//   squares and y products on the single multiplier), then hits are counted over
//   the window, the scan restarts, and the window is scanned wire by wire with a
//   point emitted for each hit. An empty window ends the pair before the y term.
//   The next request is taken once the last point is in the output register.
// Reset clears the wire map and sets cosine 1.0, sine 0. When point is
//   stalled, one finished point waits in the output register and the scan
//   holds until it is taken.
// ---------------------------------------------------------------------------
module uv_strip_wire_point_matcher_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    uvswpm_in_if.sink                         req,
    uvswpm_out_if.source                      point,
    input  logic                              cfg_we,
    input  logic [uvswpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uvswpm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import uvswpm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    uvswpm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    uvswpm_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .point     (point),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> hdl/uvswpm_isqrt.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvswpm_isqrt
// Restoring integer square root, one root bit per cycle, with remainder.
// ---------------------------------------------------------------------------
module uvswpm_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          short_run,
    input  logic [uvswpm_pkg::RAD_W-1:0]  radicand,
    output logic                          busy,
    output logic [uvswpm_pkg::ROOT_W-1:0] root,
    output logic [uvswpm_pkg::REM_W-1:0]  rem
);
    import uvswpm_pkg::*;

    localparam int STEP_W      = $clog2(ROOT_W);
    localparam int LONG_STEPS  = ROOT_W - 1;
    localparam int SHORT_STEPS = ROOT_W / 2 - 1;
    localparam int SH_W        = REM_W + 2;

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [STEP_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;

    logic [SH_W-1:0]   rem_sh;
    logic [SH_W-1:0]   trial;
    logic [SH_W-1:0]   diff;
    logic              fits;

    always_comb
    begin
        rem_sh = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial  = {2'b00, root_reg, 2'b01};
        diff   = rem_sh - trial;
        fits   = (rem_sh >= trial);
    end

    always_comb
    begin
        rad_next  = rad_reg;
        root_next = root_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            // a short run takes a 16-bit radicand, aligned to the top
            rad_next  = short_run ? {radicand[RAD_W/2-1:0], {(RAD_W/2){1'b0}}} : radicand;
            root_next = '0;
            rem_next  = '0;
            cnt_next  = short_run ? STEP_W'(SHORT_STEPS) : STEP_W'(LONG_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            root_next = {root_reg[ROOT_W-2:0], fits};
            rem_next  = fits ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
            cnt_next  = cnt_reg - STEP_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;
    assign rem  = rem_reg;

endmodule

>>> hdl/uvswpm_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// uvswpm_dpath
// Wire map, window bounds, shared multiplier, scan counters and point output.
// ---------------------------------------------------------------------------
module uvswpm_dpath (
    input  logic                              clk,
    input  logic                              rst_n,
    uvswpm_in_if.sink                         req,
    uvswpm_out_if.source                      point,
    input  logic                              cfg_we,
    input  logic [uvswpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [uvswpm_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  uvswpm_pkg::dp_cmd_t               cmd,
    output uvswpm_pkg::dp_stat_t              stat
);
    import uvswpm_pkg::*;

    localparam int SUM_W = PROD_W + 9;
    localparam int Q_W   = SUM_W - 14;

    // configuration
    logic signed [CFG_DATA_W-1:0] cos_reg;
    logic signed [CFG_DATA_W-1:0] sin_reg;

    // wire map
    logic [NUM_WIRES-1:0] hits_reg;

    // request payload
    logic [7:0] ub_reg, ue_reg, up_reg, uw_reg;
    logic [7:0] vb_reg, ve_reg, vp_reg, vw_reg;
    logic [4:0] layer_reg;

    // pair working registers
    logic [16:0]                sq_reg;
    logic signed [WIN_W-1:0]    left_reg;
    logic signed [WIN_W-1:0]    right_reg;
    logic signed [16:0]         y_reg;
    logic signed [PROD_W-1:0]   ysin_reg, ycos_reg, xcos_reg, xsin_reg;
    logic [WIRE_W-1:0]          idx_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [CNT_W-1:0]           n_reg;
    logic                       out_valid_reg;

    logic signed [16:0]         x_out_reg, y_out_reg;
    logic [4:0]                 layer_out_reg;
    logic [7:0]                 res_out_reg;
    logic                       ovf_out_reg, last_out_reg;

    logic                       take;
    logic signed [9:0]          dl, dr;
    logic [8:0]                 ml, mr;
    logic signed [8:0]          s_diff;
    logic [7:0]                 s_mag;
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]   prod;
    logic signed [WIN_W-1:0]    xoff;

    logic                       isq_busy;
    logic [ROOT_W-1:0]          isq_root;
    logic [REM_W-1:0]           isq_rem;
    logic [RAD_W-1:0]           isq_rad;

    logic signed [WIN_W-1:0]    q_w;
    logic signed [WIN_W-1:0]    left_sum, right_sum;
    logic                       dr_pos;
    logic [16:0]                y_mag;
    logic [CNT_W-1:0]           emit_n;
    logic                       hit;
    logic                       at_right;
    logic                       out_busy;
    logic                       is_last;
    logic [8:0]                 res_sum;
    logic signed [SUM_W-1:0]    x_sum, y_sum;

    function automatic logic signed [16:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        logic signed [Q_W-1:0]   q;
        begin
            t = v + SUM_W'(8192);
            q = $signed(t[SUM_W-1:14]);
            if (q > Q_W'(65535))
            begin
                round_sat = 17'sd65535;
            end
            else if (q < -Q_W'(65536))
            begin
                round_sat = -17'sd65536;
            end
            else
            begin
                round_sat = q[16:0];
            end
        end
    endfunction

    assign take = req.valid && cmd.accept_en;
    assign req.ready = cmd.accept_en;

    // window and peak differences
    always_comb
    begin
        dl     = 10'(STRIP_SUM) - $signed({2'b00, ub_reg}) - $signed({2'b00, vb_reg});
        dr     = 10'(STRIP_SUM) - $signed({2'b00, ue_reg}) - $signed({2'b00, ve_reg});
        ml     = dl[9] ? 9'(-dl) : dl[8:0];
        mr     = dr[9] ? 9'(-dr) : dr[8:0];
        s_diff = $signed({1'b0, vp_reg}) - $signed({1'b0, up_reg});
        s_mag  = s_diff[8] ? 8'(-s_diff) : s_diff[7:0];
        xoff   = $signed({{(WIN_W - WIRE_W){1'b0}}, idx_reg}) - WIN_W'(WIRE_OFFSET);
    end

    // single shared multiplier, each selected product lands in a register
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            MUL_SQ_L:
            begin
                mul_a = $signed(MUL_A_W'(ml));
                mul_b = $signed(MUL_B_W'(ml));
            end
            MUL_SQ_R:
            begin
                mul_a = $signed(MUL_A_W'(mr));
                mul_b = $signed(MUL_B_W'(mr));
            end
            MUL_SQ_Y:
            begin
                mul_a = $signed(MUL_A_W'(s_mag));
                mul_b = $signed(MUL_B_W'(s_mag));
            end
            MUL_Y_SIN:
            begin
                mul_a = MUL_A_W'(y_reg);
                mul_b = MUL_B_W'(sin_reg);
            end
            MUL_Y_COS:
            begin
                mul_a = MUL_A_W'(y_reg);
                mul_b = MUL_B_W'(cos_reg);
            end
            MUL_X_COS:
            begin
                mul_a = MUL_A_W'(xoff);
                mul_b = MUL_B_W'(cos_reg);
            end
            MUL_X_SIN:
            begin
                mul_a = MUL_A_W'(xoff);
                mul_b = MUL_B_W'(sin_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // floor(m/sqrt2) = isqrt(m*m/2); y uses isqrt(2*a*a) with a = |s|*128
    assign isq_rad = cmd.isq_short ? RAD_W'(sq_reg[16:1])
                                   : {1'b0, sq_reg[15:0], 15'b0};

    uvswpm_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.isq_start),
        .short_run (cmd.isq_short),
        .radicand  (isq_rad),
        .busy      (isq_busy),
        .root      (isq_root),
        .rem       (isq_rem)
    );

    always_comb
    begin
        q_w       = $signed(WIN_W'(isq_root));
        left_sum  = (dl[9] ? ~q_w : q_w) + WIN_W'(WIRE_OFFSET);
        dr_pos    = !dr[9] && (dr != '0);
        right_sum = (dr_pos ? q_w + WIN_W'(1) : -q_w) + WIN_W'(WIRE_OFFSET);
        // round to nearest: bump when the remainder exceeds the root
        y_mag     = {1'b0, isq_root} + 17'(isq_rem > REM_W'(isq_root));
    end

    always_comb
    begin
        hit      = hits_reg[idx_reg];
        at_right = (idx_reg == right_reg[WIRE_W-1:0]);
        emit_n   = (cnt_reg > CNT_W'(EMIT_MAX)) ? CNT_W'(EMIT_MAX) : cnt_reg;
        is_last  = ((n_reg + CNT_W'(1)) == emit_n);
        out_busy = out_valid_reg && !point.ready;
        res_sum  = {1'b0, uw_reg} + {2'b00, vw_reg[7:1]};
        x_sum    = ($signed(SUM_W'(xcos_reg)) <<< 8) - SUM_W'(ysin_reg);
        y_sum    = ($signed(SUM_W'(xsin_reg)) <<< 8) + SUM_W'(ycos_reg);
    end

    always_comb
    begin
        stat.req_valid = req.valid;
        stat.req_mode  = req.mode;
        stat.isq_busy  = isq_busy;
        stat.win_empty = (left_reg > right_reg);
        stat.hit       = hit;
        stat.at_right  = at_right;
        stat.cnt_zero  = (cnt_reg == '0);
        stat.is_last   = is_last;
        stat.out_busy  = out_busy;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg       <= CFG_DATA_W'(16384);
            sin_reg       <= '0;
            hits_reg      <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_ROT_COS: cos_reg <= $signed(cfg_wdata);
                    CFG_ROT_SIN: sin_reg <= $signed(cfg_wdata);
                    default:     cos_reg <= cos_reg;
                endcase
            end

            if (take && (req.mode == MODE_CLEAR))
            begin
                hits_reg <= '0;
            end
            else if (take && (req.mode == MODE_MARK) && (32'(req.wire_req) < NUM_WIRES))
            begin
                hits_reg[WIRE_W'(req.wire_req)] <= 1'b1;
            end

            if (cmd.idx_load)
            begin
                idx_reg <= left_reg[WIRE_W-1:0];
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + WIRE_W'(1);
            end

            // hit count saturates one above the limit so overflow stays visible
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_acc && hit && (cnt_reg != CNT_W'(MAX_HITS + 1)))
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end

            if (cmd.n_clr)
            begin
                n_reg <= '0;
            end
            else if (cmd.out_load)
            begin
                n_reg <= n_reg + CNT_W'(1);
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (point.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            ub_reg    <= req.u_begin;
            ue_reg    <= req.u_end;
            up_reg    <= req.u_peak;
            uw_reg    <= req.u_width;
            vb_reg    <= req.v_begin;
            ve_reg    <= req.v_end;
            vp_reg    <= req.v_peak;
            vw_reg    <= req.v_width;
            layer_reg <= req.layer;
        end

        case (cmd.mul_sel)
            MUL_SQ_L, MUL_SQ_R, MUL_SQ_Y: sq_reg   <= prod[16:0];
            MUL_Y_SIN:                    ysin_reg <= prod;
            MUL_Y_COS:                    ycos_reg <= prod;
            MUL_X_COS:                    xcos_reg <= prod;
            MUL_X_SIN:                    xsin_reg <= prod;
            default:                      sq_reg   <= sq_reg;
        endcase

        if (cmd.cap_left)
        begin
            left_reg <= left_sum[WIN_W-1] ? '0 : left_sum;
        end
        if (cmd.cap_right)
        begin
            right_reg <= (right_sum > WIN_W'(NUM_WIRES - 1)) ? WIN_W'(NUM_WIRES - 1)
                                                             : right_sum;
        end
        if (cmd.cap_y)
        begin
            y_reg <= s_diff[8] ? -$signed(y_mag) : $signed(y_mag);
        end

        if (cmd.out_load)
        begin
            x_out_reg     <= round_sat(x_sum);
            y_out_reg     <= round_sat(y_sum);
            layer_out_reg <= layer_reg;
            res_out_reg   <= res_sum[8:1];
            ovf_out_reg   <= (cnt_reg > CNT_W'(MAX_HITS));
            last_out_reg  <= is_last;
        end
    end

    assign point.valid       = out_valid_reg;
    assign point.x_pos       = x_out_reg;
    assign point.y_pos       = y_out_reg;
    assign point.point_layer = layer_out_reg;
    assign point.resolution  = res_out_reg;
    assign point.overflow    = ovf_out_reg;
    assign point.last        = last_out_reg;

    `UV_ASSERT(a_isq_start_idle, cmd.isq_start |-> !isq_busy, "square root restarted while busy")
    `UV_ASSERT(a_load_free, cmd.out_load |-> !out_busy, "point loaded over a pending point")
    `UV_ASSERT(a_load_budget, cmd.out_load |-> (n_reg < emit_n), "more points than the hit budget")
    `UV_ASSERT(a_scan_window, cmd.idx_inc |-> !at_right, "scan stepped past the window")
    `UV_ASSERT(a_valid_from_load, $rose(out_valid_reg) |-> $past(cmd.out_load), "point valid without load")
    `UV_ASSERT_ALWAYS(a_accept_isq_idle, cmd.accept_en |-> !isq_busy, "request accepted during a root")

endmodule

>>> hdl/uvswpm_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uvswpm_ctrl
// Sequencer for window bounds, y term, hit count pass and point emission.
// ---------------------------------------------------------------------------
module uvswpm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  uvswpm_pkg::dp_stat_t stat,
    output uvswpm_pkg::dp_cmd_t  cmd
);
    import uvswpm_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (stat.req_valid && (stat.req_mode == MODE_PAIR))
                begin
                    state_next = ST_SQ_L;
                end
            end
            ST_SQ_L:  state_next = ST_RT_L;
            ST_RT_L:  state_next = ST_WT_L;
            ST_WT_L:
            begin
                if (!stat.isq_busy)
                begin
                    state_next = ST_SQ_R;
                end
            end
            ST_SQ_R:  state_next = ST_RT_R;
            ST_RT_R:  state_next = ST_WT_R;
            ST_WT_R:
            begin
                if (!stat.isq_busy)
                begin
                    state_next = ST_CHK;
                end
            end
            ST_CHK:   state_next = stat.win_empty ? ST_IDLE : ST_SQ_Y;
            ST_SQ_Y:  state_next = ST_RT_Y;
            ST_RT_Y:  state_next = ST_WT_Y;
            ST_WT_Y:
            begin
                if (!stat.isq_busy)
                begin
                    state_next = ST_M_YS;
                end
            end
            ST_M_YS:  state_next = ST_M_YC;
            ST_M_YC:  state_next = ST_COUNT;
            ST_COUNT:
            begin
                if (stat.at_right)
                begin
                    state_next = ST_E_INIT;
                end
            end
            ST_E_INIT: state_next = stat.cnt_zero ? ST_IDLE : ST_E_SCAN;
            ST_E_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = ST_E_MS;
                end
                else if (stat.at_right)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_E_MS:  state_next = ST_E_OUT;
            ST_E_OUT:
            begin
                if (!stat.out_busy)
                begin
                    state_next = stat.is_last ? ST_IDLE : ST_E_SCAN;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:  cmd.accept_en = 1'b1;
            ST_SQ_L:  cmd.mul_sel = MUL_SQ_L;
            ST_RT_L:
            begin
                cmd.isq_start = 1'b1;
                cmd.isq_short = 1'b1;
            end
            ST_WT_L:  cmd.cap_left = !stat.isq_busy;
            ST_SQ_R:  cmd.mul_sel = MUL_SQ_R;
            ST_RT_R:
            begin
                cmd.isq_start = 1'b1;
                cmd.isq_short = 1'b1;
            end
            ST_WT_R:  cmd.cap_right = !stat.isq_busy;
            ST_CHK:   cmd = '0;
            ST_SQ_Y:  cmd.mul_sel = MUL_SQ_Y;
            ST_RT_Y:  cmd.isq_start = 1'b1;
            ST_WT_Y:  cmd.cap_y = !stat.isq_busy;
            ST_M_YS:  cmd.mul_sel = MUL_Y_SIN;
            ST_M_YC:
            begin
                cmd.mul_sel  = MUL_Y_COS;
                cmd.idx_load = 1'b1;
                cmd.cnt_clr  = 1'b1;
            end
            ST_COUNT:
            begin
                cmd.cnt_acc = 1'b1;
                cmd.idx_inc = !stat.at_right;
            end
            ST_E_INIT:
            begin
                cmd.idx_load = 1'b1;
                cmd.n_clr    = 1'b1;
            end
            ST_E_SCAN:
            begin
                if (stat.hit)
                begin
                    cmd.mul_sel = MUL_X_COS;
                end
                else
                begin
                    cmd.idx_inc = !stat.at_right;
                end
            end
            ST_E_MS:  cmd.mul_sel = MUL_X_SIN;
            ST_E_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    cmd.idx_inc  = !stat.is_last;
                end
            end
            default:  cmd = '0;
        endcase
    end

endmodule

>>> dv/uv_strip_wire_point_matcher_unit_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// uv_strip_wire_point_matcher_unit_test
// Self-checking bench for the U/V point matcher. A behavioral predictor keeps
// its own wire map and rotation, works out the points of every accepted
// request and checks them in order against the point channel, under random
// idling on both channels, rotation changes and a long output stall.
// ---------------------------------------------------------------------------
module uv_strip_wire_point_matcher_unit_test;
    import uvswpm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int QUIET_CYCLES   = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_ITEMS   = 16;
    localparam int MAX_STRIP_SUM  = 510;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [1:0] mode;
        logic [6:0] wire_req;
        logic [7:0] u_begin;
        logic [7:0] u_end;
        logic [7:0] u_peak;
        logic [7:0] u_width;
        logic [7:0] v_begin;
        logic [7:0] v_end;
        logic [7:0] v_peak;
        logic [7:0] v_width;
        logic [4:0] layer;
    } request_t;

    typedef struct {
        logic signed [16:0] x_pos;
        logic signed [16:0] y_pos;
        logic [4:0]         point_layer;
        logic [7:0]         resolution;
        logic               overflow;
        logic               last;
    } space_point_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    uvswpm_in_if  req_ch ();
    uvswpm_out_if point_ch ();

    uv_strip_wire_point_matcher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .point     (point_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state
    bit                 wire_map [NUM_WIRES];
    logic signed [15:0] model_cos = 16'sd16384;
    logic signed [15:0] model_sin = 16'sd0;
    space_point_t       expected_points [$];

    int mismatch_count    = 0;
    int idle_cycles       = 0;
    int send_gap_pct      = 0;
    int stall_pct         = 0;
    int stall_cycles_left = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n    -= root + probe;
                root  = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    // floor(|d| / sqrt2)
    function automatic longint scaled_mag(longint d);
        longint unsigned m;
        m = (d < 0) ? -d : d;
        return longint'(int_sqrt(m * m / 2));
    endfunction

    function automatic longint window_left(longint d);
        longint k;
        k = scaled_mag(d);
        return ((d >= 0) ? k : -(k + 1)) + WIRE_OFFSET;
    endfunction

    function automatic longint window_right(longint d);
        longint k;
        k = scaled_mag(d);
        if (d > 0)
            return k + 1 + WIRE_OFFSET;
        if (d == 0)
            return WIRE_OFFSET;
        return -k + WIRE_OFFSET;
    endfunction

    // divide by 2^14 rounding half up, then saturate to 17 bits
    function automatic logic signed [16:0] q14_round(longint v);
        longint q;
        q = (v + 8192) >>> 14;
        if (q > 65535)
            q = 65535;
        if (q < -65536)
            q = -65536;
        return q[16:0];
    endfunction

    function automatic void predict_request(request_t r);
        longint          left;
        longint          right;
        longint          s;
        longint          y;
        longint          xc;
        longint          w;
        longint unsigned a;
        longint unsigned k;
        int              total;
        int              emit;
        int              n;
        logic            ovf;
        logic [7:0]      res;
        space_point_t    p;
        case (r.mode)
            MODE_CLEAR:
                foreach (wire_map[i])
                    wire_map[i] = 1'b0;
            MODE_MARK:
                if (r.wire_req < NUM_WIRES)
                    wire_map[r.wire_req] = 1'b1;
            MODE_PAIR:
            begin
                left  = window_left(longint'(STRIP_SUM) - longint'(r.u_begin)
                                    - longint'(r.v_begin));
                right = window_right(longint'(STRIP_SUM) - longint'(r.u_end)
                                     - longint'(r.v_end));
                if (left < 0)
                    left = 0;
                if (right > NUM_WIRES - 1)
                    right = NUM_WIRES - 1;
                if (left > right)
                    return;
                // y = (v_peak - u_peak) * 128 * sqrt2, rounded to nearest
                s = longint'(r.v_peak) - longint'(r.u_peak);
                a = ((s < 0) ? -s : s) * 128;
                k = int_sqrt(2 * a * a);
                if (a != 0 && 8 * a * a >= (2 * k + 1) * (2 * k + 1))
                    k++;
                y   = (s < 0) ? -longint'(k) : longint'(k);
                res = 8'((longint'(r.u_width) + longint'(r.v_width) / 2) / 2);
                total = 0;
                for (w = left; w <= right; w++)
                    if (wire_map[w])
                        total++;
                emit = (total < EMIT_MAX) ? total : EMIT_MAX;
                ovf  = (total > MAX_HITS);
                n    = 0;
                for (w = left; w <= right && n < emit; w++)
                begin
                    if (wire_map[w])
                    begin
                        xc            = (w - WIRE_OFFSET) * 256;
                        p.x_pos       = q14_round(xc * model_cos - y * model_sin);
                        p.y_pos       = q14_round(xc * model_sin + y * model_cos);
                        p.point_layer = r.layer;
                        p.resolution  = res;
                        p.overflow    = ovf;
                        p.last        = (n == emit - 1);
                        expected_points.insert(expected_points.size(), p);
                        n++;
                    end
                end
            end
            default:
                ;
        endcase
    endfunction

    always @(posedge clk)
    begin : request_monitor
        request_t seen;
        if (rst_n === 1'b1 && req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        begin
            seen.mode     = req_ch.mode;
            seen.wire_req = req_ch.wire_req;
            seen.u_begin  = req_ch.u_begin;
            seen.u_end    = req_ch.u_end;
            seen.u_peak   = req_ch.u_peak;
            seen.u_width  = req_ch.u_width;
            seen.v_begin  = req_ch.v_begin;
            seen.v_end    = req_ch.v_end;
            seen.v_peak   = req_ch.v_peak;
            seen.v_width  = req_ch.v_width;
            seen.layer    = req_ch.layer;
            predict_request(seen);
        end
    end

    always @(posedge clk)
    begin : point_checker
        space_point_t want;
        if (rst_n === 1'b1 && point_ch.valid === 1'b1 && point_ch.ready === 1'b1)
        begin
            if (expected_points.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected point: x=%0d y=%0d layer=%0d res=%0d ovf=%0b last=%0b",
                             point_ch.x_pos, point_ch.y_pos, point_ch.point_layer,
                             point_ch.resolution, point_ch.overflow, point_ch.last);
            end
            else
            begin
                want = expected_points.pop_front();
                if (want.x_pos !== point_ch.x_pos || want.y_pos !== point_ch.y_pos
                    || want.point_layer !== point_ch.point_layer
                    || want.resolution !== point_ch.resolution
                    || want.overflow !== point_ch.overflow || want.last !== point_ch.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("point mismatch: expected x=%0d y=%0d layer=%0d res=%0d ovf=%0b last=%0b",
                                 want.x_pos, want.y_pos, want.point_layer, want.resolution,
                                 want.overflow, want.last);
                        $display("                actual   x=%0d y=%0d layer=%0d res=%0d ovf=%0b last=%0b",
                                 point_ch.x_pos, point_ch.y_pos, point_ch.point_layer,
                                 point_ch.resolution, point_ch.overflow, point_ch.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
            || (point_ch.valid === 1'b1 && point_ch.ready === 1'b1))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // point receiver: random stalls, plus a long hold when one is requested
    always @(negedge clk)
    begin
        if (stall_cycles_left > 0)
        begin
            point_ch.ready = 1'b0;
            stall_cycles_left--;
        end
        else
            point_ch.ready = ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic logic [4:0] random_layer();
        if ($urandom_range(0, 9) == 0)
            return 5'($urandom_range(0, 31));
        return 5'($urandom_range(1, 24));
    endfunction

    function automatic request_t random_request();
        request_t r;
        r.mode     = 2'($urandom_range(0, 3));
        r.wire_req = 7'($urandom_range(0, 127));
        r.u_begin  = 8'($urandom_range(0, 255));
        r.u_end    = 8'($urandom_range(0, 255));
        r.u_peak   = 8'($urandom_range(0, 255));
        r.u_width  = 8'($urandom_range(0, 255));
        r.v_begin  = 8'($urandom_range(0, 255));
        r.v_end    = 8'($urandom_range(0, 255));
        r.v_peak   = 8'($urandom_range(0, 255));
        r.v_width  = 8'($urandom_range(0, 255));
        r.layer    = random_layer();
        return r;
    endfunction

    function automatic request_t wire_command(logic [1:0] mode, int wire_num);
        request_t r;
        r          = random_request();
        r.mode     = mode;
        r.wire_req = wire_num[6:0];
        return r;
    endfunction

    function automatic request_t cluster_pair(int ub, int ue, int up, int uw,
                                              int vb, int ve, int vp, int vw, int layer);
        request_t r;
        r         = random_request();
        r.mode    = MODE_PAIR;
        r.u_begin = ub[7:0];
        r.u_end   = ue[7:0];
        r.u_peak  = up[7:0];
        r.u_width = uw[7:0];
        r.v_begin = vb[7:0];
        r.v_end   = ve[7:0];
        r.v_peak  = vp[7:0];
        r.v_width = vw[7:0];
        r.layer   = layer[4:0];
        return r;
    endfunction

    // strip sums that put the window near centre +- half (181/128 ~ sqrt2)
    function automatic request_t aimed_pair(int centre, int half);
        int sum_b;
        int sum_e;
        int ub;
        int ue;
        sum_b = STRIP_SUM - ((centre - half - WIRE_OFFSET) * 181) / 128;
        sum_e = STRIP_SUM - ((centre + half - WIRE_OFFSET) * 181) / 128;
        sum_b = (sum_b < 0) ? 0 : (sum_b > MAX_STRIP_SUM) ? MAX_STRIP_SUM : sum_b;
        sum_e = (sum_e < 0) ? 0 : (sum_e > MAX_STRIP_SUM) ? MAX_STRIP_SUM : sum_e;
        ub = $urandom_range((sum_b > 255) ? sum_b - 255 : 0, (sum_b < 255) ? sum_b : 255);
        ue = $urandom_range((sum_e > 255) ? sum_e - 255 : 0, (sum_e < 255) ? sum_e : 255);
        return cluster_pair(ub, ue, $urandom_range(0, 255), $urandom_range(0, 255),
                            sum_b - ub, sum_e - ue, $urandom_range(0, 255),
                            $urandom_range(0, 255), random_layer());
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input request_t r);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.mode     = r.mode;
        req_ch.wire_req = r.wire_req;
        req_ch.u_begin  = r.u_begin;
        req_ch.u_end    = r.u_end;
        req_ch.u_peak   = r.u_peak;
        req_ch.u_width  = r.u_width;
        req_ch.v_begin  = r.v_begin;
        req_ch.v_end    = r.v_end;
        req_ch.v_peak   = r.v_peak;
        req_ch.v_width  = r.v_width;
        req_ch.layer    = r.layer;
        req_ch.valid    = 1'b1;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        @(negedge clk);
    endtask

    // a pair with an empty window or no hits gives no point, so let it finish
    task automatic wait_idle();
        req_ch.valid = 1'b0;
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    task automatic write_rotation(input cfg_idx_t idx, input logic signed [15:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_ROT_COS)
            model_cos = value;
        else
            model_sin = value;
    endtask

    task automatic set_rotation(input int cos_q14, input int sin_q14);
        wait_idle();
        write_rotation(CFG_ROT_COS, cos_q14[15:0]);
        write_rotation(CFG_ROT_SIN, sin_q14[15:0]);
    endtask

    task automatic send_hit_sequence(output int counted);
        int       marks;
        int       pairs;
        int       base;
        bit       dense;
        request_t noise;
        counted = 0;
        dense   = ($urandom_range(0, 5) == 0);
        base    = $urandom_range(0, NUM_WIRES - 22);
        if ($urandom_range(0, 3) != 0)
        begin
            send_request(wire_command(MODE_CLEAR, 0));
            counted++;
        end
        marks = dense ? $urandom_range(26, 34) : $urandom_range(2, 10);
        repeat (marks)
        begin
            if (!dense && $urandom_range(0, 4) == 0)
                send_request(wire_command(MODE_MARK, $urandom_range(0, NUM_WIRES - 1)));
            else
                send_request(wire_command(MODE_MARK, base + $urandom_range(0, 21)));
            counted++;
        end
        pairs = $urandom_range(1, 4);
        repeat (pairs)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                noise = random_request();
                send_request(noise);
                if (noise.mode != MODE_UNUSED)
                    counted++;
            end
            else
            begin
                if (dense)
                    send_request(aimed_pair(base + 11, $urandom_range(10, 16)));
                else if ($urandom_range(0, 4) == 0)
                    send_request(aimed_pair($urandom_range(0, 145) - 8, $urandom_range(0, 70)));
                else
                    send_request(aimed_pair(base + $urandom_range(0, 21), $urandom_range(0, 6)));
                counted++;
            end
        end
    endtask

    // clamping at both ends, a single-wire window, an empty window, mode 3
    task automatic test_window_edges();
        send_request(cluster_pair(255, 0, 0, 0, 255, 0, 0, 0, 1));
        send_request(wire_command(MODE_UNUSED, 5));
        send_request(wire_command(MODE_MARK, 0));
        send_request(wire_command(MODE_MARK, NUM_WIRES - 1));
        send_request(wire_command(MODE_MARK, WIRE_OFFSET));
        send_request(cluster_pair(255, 0, 255, 255, 255, 0, 0, 255, 24));
        send_request(cluster_pair(255, 0, 0, 0, 255, 0, 255, 0, 1));
        send_request(cluster_pair(120, 119, 128, 17, 119, 120, 128, 3, 12));
        send_request(cluster_pair(0, 255, 77, 9, 0, 255, 200, 40, 7));
    endtask

    // 17 hits in a full window: 16 points flagged, then clear empties the map
    task automatic test_hit_overflow();
        for (int w = 40; w < 54; w++)
            send_request(wire_command(MODE_MARK, w));
        send_request(cluster_pair(255, 0, 30, 100, 255, 0, 220, 201, 9));
        send_request(wire_command(MODE_CLEAR, 0));
        send_request(cluster_pair(255, 0, 30, 100, 255, 0, 220, 201, 9));
    endtask

    task automatic test_rotation_extremes();
        int cos_set [6] = '{-16384, 0, 0, 16384, -16384, 16384};
        int sin_set [6] = '{0, 16384, -16384, 16384, -16384, 0};
        send_request(wire_command(MODE_MARK, 0));
        send_request(wire_command(MODE_MARK, NUM_WIRES - 1));
        repeat (4) send_request(wire_command(MODE_MARK, $urandom_range(0, NUM_WIRES - 1)));
        for (int i = 0; i < 6; i++)
        begin
            set_rotation(cos_set[i], sin_set[i]);
            send_request(cluster_pair(255, 0, $urandom_range(0, 255), $urandom_range(0, 255),
                                      255, 0, $urandom_range(0, 255), $urandom_range(0, 255),
                                      random_layer()));
        end
    endtask

    task automatic test_random_traffic(input int gap_pct, input int hold_pct);
        int total;
        int n;
        send_gap_pct = gap_pct;
        stall_pct    = hold_pct;
        set_rotation($urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
        total = 0;
        while (total < RANDOM_ITEMS)
        begin
            send_hit_sequence(n);
            total += n;
        end
    endtask

    // receiver holds off while requests keep coming, so the input backs up
    task automatic test_output_backpressure();
        int base;
        send_gap_pct = 0;
        stall_pct    = 0;
        wait_idle();
        base = $urandom_range(0, NUM_WIRES - 16);
        stall_cycles_left = LONG_HOLD;
        send_request(wire_command(MODE_CLEAR, 0));
        repeat (10) send_request(wire_command(MODE_MARK, base + $urandom_range(0, 15)));
        repeat (3) send_request(aimed_pair(base + 8, $urandom_range(4, 10)));
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_ROT_COS;
        cfg_wdata        = '0;
        point_ch.ready   = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_CLEAR;
        req_ch.wire_req  = '0;
        req_ch.u_begin   = '0;
        req_ch.u_end     = '0;
        req_ch.u_peak    = '0;
        req_ch.u_width   = '0;
        req_ch.v_begin   = '0;
        req_ch.v_end     = '0;
        req_ch.v_peak    = '0;
        req_ch.v_width   = '0;
        req_ch.layer     = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_gap_pct = 17;
        stall_pct    = 73;
        test_window_edges();
        test_hit_overflow();
        test_rotation_extremes();
        test_random_traffic(17, 73);
        test_random_traffic(73, 17);
        test_random_traffic(0, 0);
        test_output_backpressure();

        wait_idle();
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/uvswpm_pkg.sv
hdl/uvswpm_in_if.sv
hdl/uvswpm_out_if.sv
hdl/uvswpm_isqrt.sv
hdl/uvswpm_dpath.sv
hdl/uvswpm_ctrl.sv
hdl/uv_strip_wire_point_matcher_unit.sv
dv/uv_strip_wire_point_matcher_unit_test.sv
